// ===== rtl/bbf_pkg.sv =====
// ----------------------------------------------------------------------------
// bbf_pkg
// shared constants, codes and types of the band-pass biquad section
// ----------------------------------------------------------------------------
package bbf_pkg;

  localparam int unsigned SAMPLE_WIDTH   = 24;
  localparam int unsigned COEF_FRAC_BITS = 30;
  localparam int unsigned COEF_WIDTH     = 32;
  localparam int unsigned GAIN_WIDTH     = 20;
  localparam int unsigned GAIN_FRAC_BITS = 16;
  localparam int unsigned CFG_IDX_W      = 2;

  // unity gain in q3.16
  localparam logic [GAIN_WIDTH-1:0] GAIN_RESET = 20'h10000;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ALPHA = 2'd0,
    CFG_GAMMA = 2'd1,
    CFG_BETA  = 2'd2,
    CFG_GAIN  = 2'd3
  } cfg_reg_e;

  typedef enum logic [1:0] {
    MSEL_ALPHA,
    MSEL_GAMMA,
    MSEL_BETA,
    MSEL_GAIN
  } mul_sel_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ALPHA,
    ST_GAMMA,
    ST_BETA,
    ST_NEG,
    ST_SATY,
    ST_GAIN,
    ST_MIX
  } state_e;

  typedef struct packed {
    mul_sel_e mul_sel;
    logic     mul_en;
    logic     acc_clr;
    logic     acc_add;
    logic     acc_sub;
    logic     y_load;
    logic     out_load;
  } ctrl_t;

endpackage

// ===== rtl/bbf_mul.sv =====
// ----------------------------------------------------------------------------
// bbf_mul
// shared signed multiplier with a registered product
// ----------------------------------------------------------------------------
module bbf_mul #(
  parameter int unsigned A_W = 25,
  parameter int unsigned B_W = 32
) (
  input  logic                        clk_i,
  input  logic                        en_i,
  input  logic signed [A_W-1:0]       a_i,
  input  logic signed [B_W-1:0]       b_i,
  output logic signed [A_W+B_W-1:0]   p_o
);

  logic signed [A_W+B_W-1:0] p_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p_q <= a_i * b_i;
    end
  end

  assign p_o = p_q;

endmodule

// ===== rtl/bbf_ctrl.sv =====
// ----------------------------------------------------------------------------
// bbf_ctrl
// sequencer that steps one item through the shared multiplier
// ----------------------------------------------------------------------------
module bbf_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  input  logic           out_busy_i,
  output logic           in_ready_o,
  output bbf_pkg::ctrl_t ctrl_o
);

  bbf_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= bbf_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      bbf_pkg::ST_IDLE:  if (in_valid_i) state_d = bbf_pkg::ST_ALPHA;
      bbf_pkg::ST_ALPHA: state_d = bbf_pkg::ST_GAMMA;
      bbf_pkg::ST_GAMMA: state_d = bbf_pkg::ST_BETA;
      bbf_pkg::ST_BETA:  state_d = bbf_pkg::ST_NEG;
      bbf_pkg::ST_NEG:   state_d = bbf_pkg::ST_SATY;
      bbf_pkg::ST_SATY:  state_d = bbf_pkg::ST_GAIN;
      bbf_pkg::ST_GAIN:  state_d = bbf_pkg::ST_MIX;
      bbf_pkg::ST_MIX:   if (!out_busy_i) state_d = bbf_pkg::ST_IDLE;
      default:           state_d = bbf_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o       = 1'b0;
    ctrl_o.mul_sel   = bbf_pkg::MSEL_ALPHA;
    ctrl_o.mul_en    = 1'b0;
    ctrl_o.acc_clr   = 1'b0;
    ctrl_o.acc_add   = 1'b0;
    ctrl_o.acc_sub   = 1'b0;
    ctrl_o.y_load    = 1'b0;
    ctrl_o.out_load  = 1'b0;
    unique case (state_q)
      bbf_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
      end
      bbf_pkg::ST_ALPHA: begin
        ctrl_o.mul_sel = bbf_pkg::MSEL_ALPHA;
        ctrl_o.mul_en  = 1'b1;
        ctrl_o.acc_clr = 1'b1;
      end
      bbf_pkg::ST_GAMMA: begin
        ctrl_o.mul_sel = bbf_pkg::MSEL_GAMMA;
        ctrl_o.mul_en  = 1'b1;
        ctrl_o.acc_add = 1'b1;
      end
      bbf_pkg::ST_BETA: begin
        ctrl_o.mul_sel = bbf_pkg::MSEL_BETA;
        ctrl_o.mul_en  = 1'b1;
        ctrl_o.acc_add = 1'b1;
      end
      bbf_pkg::ST_NEG: begin
        ctrl_o.acc_sub = 1'b1;
      end
      bbf_pkg::ST_SATY: begin
        ctrl_o.y_load = 1'b1;
      end
      bbf_pkg::ST_GAIN: begin
        ctrl_o.mul_sel = bbf_pkg::MSEL_GAIN;
        ctrl_o.mul_en  = 1'b1;
      end
      bbf_pkg::ST_MIX: begin
        ctrl_o.out_load = !out_busy_i;
      end
      default: begin
        in_ready_o = 1'b0;
      end
    endcase
  end

endmodule

// ===== rtl/biquad_bandpass_filter.sv =====
// ----------------------------------------------------------------------------
// biquad_bandpass_filter
// second-order band-pass iir section with gain and saturating mix
// ----------------------------------------------------------------------------
// Each item carries a sample and a mix value and returns
// sat(mix + gain * sat(2 * (alpha*(x - x2) + gamma*y1 - beta*y2))). One
// signed multiplier is shared by the four products of an item, so the block
// accepts a new item only after the last one is loaded into the output
// register; the input stays not ready while a result waits in the output
// register and the next one is finished. Coefficients are q1.30 and gain
// is q3.16. The user must write them through the configuration port only
// while the block is idle; the block itself does not enforce this.
module biquad_bandpass_filter #(
  parameter int unsigned SAMPLE_WIDTH   = bbf_pkg::SAMPLE_WIDTH,
  parameter int unsigned COEF_FRAC_BITS = bbf_pkg::COEF_FRAC_BITS
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [bbf_pkg::CFG_IDX_W-1:0]        cfg_index_i,
  input  logic [bbf_pkg::COEF_WIDTH-1:0]       cfg_data_i,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic signed [SAMPLE_WIDTH-1:0]       sample_in_i,
  input  logic signed [SAMPLE_WIDTH-1:0]       mix_in_i,
  input  logic                                 block_end_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic signed [SAMPLE_WIDTH-1:0]       mix_out_o,
  output logic                                 block_end_out_o
);

  localparam int unsigned SW    = SAMPLE_WIDTH;
  localparam int unsigned A_W   = SW + 1;
  localparam int unsigned B_W   = bbf_pkg::COEF_WIDTH;
  localparam int unsigned GW    = bbf_pkg::GAIN_WIDTH;
  localparam int unsigned P_W   = A_W + B_W;
  localparam int unsigned ACC_W = P_W + 2;
  localparam int unsigned MIX_W = P_W + 1;

  localparam logic signed [SW-1:0] S_MAX = {1'b0, {(SW-1){1'b1}}};
  localparam logic signed [SW-1:0] S_MIN = {1'b1, {(SW-1){1'b0}}};
  localparam logic signed [ACC_W-1:0] ACC_MAX = {{(ACC_W-SW+1){1'b0}}, {(SW-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] ACC_MIN = {{(ACC_W-SW+1){1'b1}}, {(SW-1){1'b0}}};
  localparam logic signed [MIX_W-1:0] MIX_MAX = {{(MIX_W-SW+1){1'b0}}, {(SW-1){1'b1}}};
  localparam logic signed [MIX_W-1:0] MIX_MIN = {{(MIX_W-SW+1){1'b1}}, {(SW-1){1'b0}}};

  bbf_pkg::ctrl_t ctrl;
  logic           in_fire;
  logic           out_busy;

  logic signed [B_W-1:0] alpha_q, gamma_q, beta_q;
  logic signed [GW-1:0]  gain_q;

  logic signed [A_W-1:0] diff_q;
  logic signed [SW-1:0]  x_q, mix_q;
  logic                  blk_q;
  logic signed [SW-1:0]  x_d1_q, x_d2_q, y_d1_q, y_d2_q, y_q;

  logic signed [A_W-1:0]   mul_a;
  logic signed [B_W-1:0]   mul_b;
  logic signed [P_W-1:0]   prod;
  logic signed [ACC_W-1:0] prod_ext;
  logic signed [ACC_W-1:0] acc_q, acc_d;
  logic signed [ACC_W-1:0] acc_shift;
  logic signed [SW-1:0]    y_sat;
  logic signed [P_W-1:0]   prod_shift;
  logic signed [MIX_W-1:0] mix_sum;
  logic signed [SW-1:0]    mix_sat;

  logic                  out_valid_q, out_valid_d;
  logic signed [SW-1:0]  mix_out_q;
  logic                  blk_out_q;

  assign in_fire     = in_valid_i && in_ready_o;
  assign out_busy    = out_valid_q && !out_ready_i;
  assign cfg_ready_o = 1'b1;

  bbf_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .out_busy_i (out_busy),
    .in_ready_o (in_ready_o),
    .ctrl_o     (ctrl)
  );

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      alpha_q <= '0;
      gamma_q <= '0;
      beta_q  <= '0;
      gain_q  <= bbf_pkg::GAIN_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (bbf_pkg::cfg_reg_e'(cfg_index_i))
        bbf_pkg::CFG_ALPHA: alpha_q <= cfg_data_i;
        bbf_pkg::CFG_GAMMA: gamma_q <= cfg_data_i;
        bbf_pkg::CFG_BETA:  beta_q  <= cfg_data_i;
        bbf_pkg::CFG_GAIN:  gain_q  <= cfg_data_i[GW-1:0];
        default:            gain_q  <= gain_q;
      endcase
    end
  end

  // item capture
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      diff_q <= {sample_in_i[SW-1], sample_in_i} - {x_d2_q[SW-1], x_d2_q};
      x_q    <= sample_in_i;
      mix_q  <= mix_in_i;
      blk_q  <= block_end_i;
    end
  end

  // filter history
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_d1_q <= '0;
      x_d2_q <= '0;
      y_d1_q <= '0;
      y_d2_q <= '0;
    end else if (ctrl.y_load) begin
      x_d2_q <= x_d1_q;
      x_d1_q <= x_q;
      y_d2_q <= y_d1_q;
      y_d1_q <= y_sat;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl.y_load) begin
      y_q <= y_sat;
    end
  end

  // operand select for the shared multiplier
  always_comb begin
    case (ctrl.mul_sel)
      bbf_pkg::MSEL_ALPHA: begin
        mul_a = diff_q;
        mul_b = alpha_q;
      end
      bbf_pkg::MSEL_GAMMA: begin
        mul_a = {y_d1_q[SW-1], y_d1_q};
        mul_b = gamma_q;
      end
      bbf_pkg::MSEL_BETA: begin
        mul_a = {y_d2_q[SW-1], y_d2_q};
        mul_b = beta_q;
      end
      default: begin
        mul_a = {y_q[SW-1], y_q};
        mul_b = {{(B_W-GW){gain_q[GW-1]}}, gain_q};
      end
    endcase
  end

  bbf_mul #(
    .A_W (A_W),
    .B_W (B_W)
  ) u_mul (
    .clk_i (clk_i),
    .en_i  (ctrl.mul_en),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (prod)
  );

  // accumulator
  assign prod_ext = {{(ACC_W-P_W){prod[P_W-1]}}, prod};

  always_comb begin
    acc_d = acc_q;
    if (ctrl.acc_clr) begin
      acc_d = '0;
    end else if (ctrl.acc_add) begin
      acc_d = acc_q + prod_ext;
    end else if (ctrl.acc_sub) begin
      acc_d = acc_q - prod_ext;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
  end

  // doubled sum floored to the sample grid, then saturated
  assign acc_shift = acc_q >>> (COEF_FRAC_BITS - 1);

  always_comb begin
    if (acc_shift > ACC_MAX) begin
      y_sat = S_MAX;
    end else if (acc_shift < ACC_MIN) begin
      y_sat = S_MIN;
    end else begin
      y_sat = acc_shift[SW-1:0];
    end
  end

  // gain and mix
  assign prod_shift = prod >>> bbf_pkg::GAIN_FRAC_BITS;
  assign mix_sum    = {prod_shift[P_W-1], prod_shift}
                    + {{(MIX_W-SW){mix_q[SW-1]}}, mix_q};

  always_comb begin
    if (mix_sum > MIX_MAX) begin
      mix_sat = S_MAX;
    end else if (mix_sum < MIX_MIN) begin
      mix_sat = S_MIN;
    end else begin
      mix_sat = mix_sum[SW-1:0];
    end
  end

  // output register
  always_comb begin
    out_valid_d = out_valid_q;
    if (ctrl.out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl.out_load) begin
      mix_out_q <= mix_sat;
      blk_out_q <= blk_q;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign mix_out_o       = mix_out_q;
  assign block_end_out_o = blk_out_q;

  // busy after an accepted item
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> !in_ready_o)
    else $error("input ready right after an accepted item");

  // history shifts with the new sample and output
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl.y_load |=> (x_d1_q == $past(x_q)) && (y_d1_q == $past(y_sat))
                    && (y_d2_q == $past(y_d1_q)))
    else $error("filter history not shifted");

  // a result is never loaded over one still waiting
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl.out_load |-> !out_valid_q || out_ready_i)
    else $error("output register overwritten");

  // loaded result carries the item's block end
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl.out_load |=> out_valid_o && (block_end_out_o == $past(blk_q)))
    else $error("result not presented after load");

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// self-checking bench for the band-pass biquad section
// ----------------------------------------------------------------------------
// A queue-fed driver sends sample items and a monitor checks each returned
// mix value against a bit-exact predictor of the filter and its history.
// Coefficients and gain are rewritten between phases while the block is
// idle. The phases cover directed extremes, saturation of the filter and
// of the mix, and random stable and unstable filters under several idle
// and stall patterns.
module testbench;

  localparam int unsigned SW = bbf_pkg::SAMPLE_WIDTH;
  localparam int unsigned COEF_WIDTH = bbf_pkg::COEF_WIDTH;
  localparam int unsigned GAIN_WIDTH = bbf_pkg::GAIN_WIDTH;
  localparam int unsigned GAIN_FRAC_BITS = bbf_pkg::GAIN_FRAC_BITS;
  localparam int unsigned COEF_FRAC_BITS = bbf_pkg::COEF_FRAC_BITS;
  localparam longint SMAX = (longint'(1) <<< (SW - 1)) - 1;
  localparam longint SMIN = -SMAX - 1;
  localparam longint CMAX = (longint'(1) <<< (COEF_WIDTH - 1)) - 1;
  localparam longint CMIN = -CMAX - 1;
  localparam longint GMAX = (longint'(1) <<< (GAIN_WIDTH - 1)) - 1;
  localparam longint GMIN = -GMAX - 1;
  localparam longint UNITY = longint'(1) <<< GAIN_FRAC_BITS;
  localparam longint HALF = longint'(1) <<< (COEF_FRAC_BITS - 1);
  localparam int RANDOM_PHASES = 10;
  localparam int ITEMS_PER_PHASE = 50;
  localparam int SETTLE_CYCLES = 12;
  localparam int STUCK_LIMIT = 4000;

  typedef struct {
    logic signed [SW-1:0] x;
    logic signed [SW-1:0] mix;
    logic                 blk;
  } filter_item_t;

  typedef struct {
    logic signed [SW-1:0] mix;
    logic                 blk;
  } mix_result_t;

  logic                          clk_i = 1'b0;
  logic                          rst_ni = 1'b0;
  logic                          cfg_valid = 1'b0;
  logic                          cfg_ready;
  logic [bbf_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [COEF_WIDTH-1:0]         cfg_data = '0;
  logic                          in_valid = 1'b0;
  logic                          in_ready;
  logic signed [SW-1:0]          sample_in = '0;
  logic signed [SW-1:0]          mix_in = '0;
  logic                          block_end = 1'b0;
  logic                          out_valid;
  logic                          out_ready = 1'b0;
  logic signed [SW-1:0]          mix_out;
  logic                          block_end_out;

  // predictor state
  logic signed [COEF_WIDTH-1:0] alpha_q = '0;
  logic signed [COEF_WIDTH-1:0] gamma_q = '0;
  logic signed [COEF_WIDTH-1:0] beta_q = '0;
  logic signed [GAIN_WIDTH-1:0] gain_q = bbf_pkg::GAIN_RESET;
  logic signed [SW-1:0]         x_dly1 = '0;
  logic signed [SW-1:0]         x_dly2 = '0;
  logic signed [SW-1:0]         y_dly1 = '0;
  logic signed [SW-1:0]         y_dly2 = '0;

  filter_item_t pending_items[$];
  filter_item_t cur_item;
  mix_result_t  expected_mix[$];
  int           items_in_flight = 0;
  int           errors = 0;
  int           send_idle_pct = 0;
  int           recv_stall_pct = 0;
  int           stuck_cycles = 0;
  int           send_pct_tbl[4] = '{0, 68, 0, 15};
  int           recv_pct_tbl[4] = '{0, 0, 68, 15};

  biquad_bandpass_filter uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_o    (cfg_ready),
    .cfg_index_i    (cfg_index),
    .cfg_data_i     (cfg_data),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready),
    .sample_in_i    (sample_in),
    .mix_in_i       (mix_in),
    .block_end_i    (block_end),
    .out_valid_o    (out_valid),
    .out_ready_i    (out_ready),
    .mix_out_o      (mix_out),
    .block_end_out_o(block_end_out)
  );

  always #4 clk_i = ~clk_i;

  function automatic longint clamp_sample(input longint v);
    if (v > SMAX) begin
      return SMAX;
    end
    if (v < SMIN) begin
      return SMIN;
    end
    return v;
  endfunction

  function automatic mix_result_t filter_step(input filter_item_t it);
    longint      acc;
    longint      y;
    longint      m;
    mix_result_t r;
    acc = (longint'($signed(it.x)) - longint'(x_dly2)) * longint'(alpha_q)
        + longint'(y_dly1) * longint'(gamma_q)
        - longint'(y_dly2) * longint'(beta_q);
    // doubling folded into the shift, floor rounding
    y = clamp_sample(acc >>> (COEF_FRAC_BITS - 1));
    x_dly2 = x_dly1;
    x_dly1 = it.x;
    y_dly2 = y_dly1;
    y_dly1 = y[SW-1:0];
    m = clamp_sample(longint'($signed(it.mix)) + ((longint'(gain_q) * y) >>> GAIN_FRAC_BITS));
    r.mix = m[SW-1:0];
    r.blk = it.blk;
    return r;
  endfunction

  function automatic longint random_sample();
    longint v;
    case ($urandom_range(0, 9))
      0: begin
        v = $urandom_range(0, 1) ? SMAX : SMIN;
      end
      1, 2: begin
        v = longint'($urandom_range(0, 2000)) - 1000;
      end
      default: begin
        v = longint'($signed(SW'($urandom)));
      end
    endcase
    return v;
  endfunction

  task automatic queue_item(input longint x, input longint mix, input logic blk);
    filter_item_t it;
    it.x = x[SW-1:0];
    it.mix = mix[SW-1:0];
    it.blk = blk;
    pending_items.push_back(it);
    items_in_flight++;
  endtask

  task automatic write_reg(input bbf_pkg::cfg_reg_e idx,
                           input logic [COEF_WIDTH-1:0] data);
    @(posedge clk_i);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk_i); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      bbf_pkg::CFG_ALPHA: alpha_q = data;
      bbf_pkg::CFG_GAMMA: gamma_q = data;
      bbf_pkg::CFG_BETA:  beta_q = data;
      bbf_pkg::CFG_GAIN:  gain_q = data[GAIN_WIDTH-1:0];
    endcase
  endtask

  task automatic set_filter(input longint a, input longint g, input longint b,
                            input longint gn);
    logic [31:0] rnd;
    rnd = $urandom;
    write_reg(bbf_pkg::CFG_ALPHA, a[COEF_WIDTH-1:0]);
    write_reg(bbf_pkg::CFG_GAMMA, g[COEF_WIDTH-1:0]);
    write_reg(bbf_pkg::CFG_BETA, b[COEF_WIDTH-1:0]);
    // upper data bits are don't-care for the gain register
    write_reg(bbf_pkg::CFG_GAIN, {rnd[COEF_WIDTH-1:GAIN_WIDTH], gn[GAIN_WIDTH-1:0]});
  endtask

  task automatic wait_drained();
    do @(negedge clk_i); while (items_in_flight != 0 || expected_mix.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic set_idle_mode(input int mode);
    @(negedge clk_i);
    send_idle_pct = send_pct_tbl[mode];
    recv_stall_pct = recv_pct_tbl[mode];
  endtask

  // driver
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid && in_ready) begin
        expected_mix.push_back(filter_step(cur_item));
        items_in_flight--;
      end
      if (!(in_valid && !in_ready)) begin
        if (pending_items.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          cur_item = pending_items.pop_front();
          in_valid <= 1'b1;
          sample_in <= cur_item.x;
          mix_in <= cur_item.mix;
          block_end <= cur_item.blk;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk_i) begin
    mix_result_t want;
    if (rst_ni) begin
      if (out_valid && out_ready) begin
        if (expected_mix.size() == 0) begin
          $display("%0t: unexpected item: expected none, actual mix_out=%0d block_end=%0b",
                   $time, mix_out, block_end_out);
          errors++;
        end else begin
          want = expected_mix.pop_front();
          if (mix_out !== want.mix) begin
            $display("%0t: mix_out mismatch: expected %0d, actual %0d",
                     $time, want.mix, mix_out);
            errors++;
          end
          if (block_end_out !== want.blk) begin
            $display("%0t: block_end_out mismatch: expected %0b, actual %0b",
                     $time, want.blk, block_end_out);
            errors++;
          end
        end
      end
      out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      stuck_cycles <= 0;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

  initial begin
    while (stuck_cycles < STUCK_LIMIT) @(posedge clk_i);
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    longint a;
    longint g;
    longint b;
    longint gn;
    longint bound;
    int     kind;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset coefficients: filter output is zero, mix passes through
    set_idle_mode(0);
    queue_item(0, 0, 1'b0);
    queue_item(SMAX, SMAX, 1'b1);
    queue_item(SMIN, SMIN, 1'b0);
    queue_item(SMAX, SMIN, 1'b1);
    queue_item(SMIN, SMAX, 1'b0);
    wait_drained();

    // largest alpha and gain: filter and mix overflow both ways
    set_filter(CMAX, 0, 0, GMAX);
    set_idle_mode(1);
    queue_item(SMAX, SMAX, 1'b0);
    queue_item(SMIN, SMIN, 1'b1);
    queue_item(SMIN, SMAX, 1'b0);
    queue_item(SMAX, 0, 1'b0);
    queue_item(0, SMIN, 1'b1);
    queue_item(0, 0, 1'b0);
    wait_drained();

    // most negative coefficients and gain
    set_filter(CMIN, CMIN, CMIN, GMIN);
    set_idle_mode(2);
    queue_item(SMAX, SMAX, 1'b0);
    queue_item(SMIN, SMIN, 1'b1);
    queue_item(SMAX, 0, 1'b0);
    queue_item(0, 0, 1'b1);
    queue_item(1, -1, 1'b0);
    wait_drained();

    // impulse response of a resonant section
    set_filter(longint'(1) <<< 28, (HALF * 9) / 5, (HALF * 4) / 5, UNITY);
    set_idle_mode(3);
    queue_item(SMAX, 0, 1'b0);
    repeat (6) queue_item(0, 0, 1'b0);
    wait_drained();

    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      kind = ph % 4;
      // stable band-pass: 0 <= beta < 0.5, |gamma| < 0.5 + beta, alpha = (0.5 - beta) / 2
      b = $urandom_range(0, (HALF * 49) / 50);
      bound = ((HALF + b) * 99) / 100;
      g = longint'($urandom_range(0, 2 * bound)) - bound;
      a = (HALF - b) / 2;
      gn = $urandom_range(UNITY / 4, UNITY * 2);
      if (kind == 1) begin
        gn = longint'($signed(GAIN_WIDTH'($urandom)));
      end else if (kind == 2) begin
        a = longint'($signed(COEF_WIDTH'($urandom)));
        g = longint'($signed(COEF_WIDTH'($urandom)));
        b = longint'($signed(COEF_WIDTH'($urandom)));
        gn = longint'($signed(GAIN_WIDTH'($urandom)));
      end else if (kind == 3) begin
        gn = $urandom_range(0, 1) ? GMAX : GMIN;
      end
      set_filter(a, g, b, gn);
      set_idle_mode(ph % 4 == 0 ? 0 : (ph + 1) % 4);
      repeat (ITEMS_PER_PHASE) begin
        queue_item(random_sample(), random_sample(), $urandom_range(0, 15) == 0);
      end
      wait_drained();
    end

    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
